// ===== hw/rtl/qri_pkg.sv =====
// qri_pkg: shared types, constants and saturation helpers for the
// quaternion RK4 integrator. No dependencies.
`timescale 1ns / 1ps

package qri_pkg;

    // field widths
    localparam int QW   = 32;   // quaternion component, Q2.30
    localparam int RW   = 32;   // body rate, Q12.20
    localparam int STW  = 24;   // step time, unsigned Q0.24
    localparam int WW   = 61;   // wide Q.30 intermediate
    localparam int HW   = 41;   // half-step rate, Q.30
    localparam int PRW  = 57;   // step time times rate

    // register stages from input beat to output register, inclusive
    localparam int PIPE_LEN = 28;

    localparam logic [STW-1:0] STEP_TIME_RESET = 24'd16777;

    typedef logic signed [QW-1:0] q_t;
    typedef logic signed [WW-1:0] wide_t;
    typedef logic signed [HW-1:0] half_t;

    typedef struct packed {
        q_t s;
        q_t x;
        q_t y;
        q_t z;
    } qquat_t;

    typedef struct packed {
        wide_t s;
        wide_t x;
        wide_t y;
        wide_t z;
    } wquat_t;

    typedef struct packed {
        half_t x;
        half_t y;
        half_t z;
    } hvec_t;

    localparam wide_t WIDE_MAX = {1'b0, {(WW-1){1'b1}}};
    localparam wide_t WIDE_MIN = {1'b1, {(WW-1){1'b0}}};
    localparam logic signed [63:0] WIDE_MAX64 = {{(65-WW){1'b0}}, {(WW-1){1'b1}}};
    localparam logic signed [63:0] WIDE_MIN64 = {{(65-WW){1'b1}}, {(WW-1){1'b0}}};

    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;

    // divide by 3 via reciprocal: x < 2^34, floor(x*RECIP3 / 2^35)
    localparam int DIVW = 34;
    localparam logic [DIVW-1:0] RECIP3 = 34'd11453246123;
    // |s|/2 at or above this saturates the result whatever q is
    localparam logic [61:0] DIV_LIM = 62'h3_0000_0000;

    function automatic logic signed [63:0] ext64(input wide_t v);
        return {{(64-WW){v[WW-1]}}, v};
    endfunction

    function automatic wide_t sat_wide(input logic signed [63:0] v);
        wide_t r;
        if (v > WIDE_MAX64)
            r = WIDE_MAX;
        else if (v < WIDE_MIN64)
            r = WIDE_MIN;
        else
            r = v[WW-1:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/qri_intf.sv =====
// qri_intf: valid/ready channel interfaces for the integrator ports.
// Depends on qri_pkg.
`timescale 1ns / 1ps

interface qri_in_if;
    logic     valid;
    logic     ready;
    qri_pkg::q_t quat_scalar;
    qri_pkg::q_t quat_x;
    qri_pkg::q_t quat_y;
    qri_pkg::q_t quat_z;
    logic signed [qri_pkg::RW-1:0] rate_x;
    logic signed [qri_pkg::RW-1:0] rate_y;
    logic signed [qri_pkg::RW-1:0] rate_z;

    modport source (output valid, quat_scalar, quat_x, quat_y, quat_z,
                    rate_x, rate_y, rate_z, input ready);
    modport sink   (input valid, quat_scalar, quat_x, quat_y, quat_z,
                    rate_x, rate_y, rate_z, output ready);
endinterface

interface qri_out_if;
    logic     valid;
    logic     ready;
    qri_pkg::q_t next_scalar;
    qri_pkg::q_t next_x;
    qri_pkg::q_t next_y;
    qri_pkg::q_t next_z;

    modport source (output valid, next_scalar, next_x, next_y, next_z, input ready);
    modport sink   (input valid, next_scalar, next_x, next_y, next_z, output ready);
endinterface

interface qri_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [qri_pkg::STW-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/quaternion_rk4_integrator.sv =====
// Quaternion RK4 integrator: a register pipeline from input beat to result.
// Throughput one beat per cycle; the whole pipe advances whenever the
// output register is empty or being taken, so a stalled result freezes it.
// Four derivative units run in series along the pipe, with stage points between them.
// Reset (rst_n, async, active low) empties the pipe and sets step_time to 16777.
`timescale 1ns / 1ps

module quaternion_rk4_integrator (
    input  logic clk,
    input  logic rst_n,
    qri_cfg_if.sink   cfg,
    qri_in_if.sink    sample,
    qri_out_if.source result
);

    localparam int PRW = qri_pkg::PRW;
    localparam int HW  = qri_pkg::HW;
    localparam logic signed [PRW-1:0] H_BIAS = PRW'(32767);

    logic [qri_pkg::STW-1:0]   step_time_reg;
    logic [qri_pkg::PIPE_LEN-1:0] valid_reg;
    logic [qri_pkg::PIPE_LEN-1:0] valid_next;
    logic en;

    qri_pkg::qquat_t q0_reg, q1_reg;
    logic signed [PRW-1:0] prod_reg [3];
    logic signed [PRW-1:0] prod_next [3];
    logic signed [PRW-1:0] adj [3];
    logic signed [qri_pkg::RW-1:0] rate_in [3];
    qri_pkg::hvec_t  h_reg, h_next, h_d1, h_d2, h_d3;
    qri_pkg::qquat_t q_t6, q_t12, q_t18, q_t24;
    qri_pkg::wquat_t p1, k1, k2, k3, k4;
    qri_pkg::wquat_t p2_reg, p3_reg, p4_reg;
    qri_pkg::wquat_t k1_d, k2_d, k3_d;
    qri_pkg::wide_t  k1a [4], k2a [4], k3a [4], k4a [4];
    qri_pkg::q_t     qa [4], r_lane [4];

    function automatic qri_pkg::wide_t widen(input qri_pkg::q_t v);
        return {{(qri_pkg::WW-qri_pkg::QW){v[qri_pkg::QW-1]}}, v};
    endfunction

    // stage point: q + k (halved toward zero when asked), saturated wide
    function automatic qri_pkg::wide_t upd(input qri_pkg::q_t q,
                                           input qri_pkg::wide_t k,
                                           input logic halve);
        logic signed [63:0] kk;
        logic signed [63:0] qq;
        kk = qri_pkg::ext64(k);
        if (halve)
        begin
            kk = kk + {63'b0, k[qri_pkg::WW-1]};
            kk = kk >>> 1;
        end
        qq = {{32{q[31]}}, q};
        return qri_pkg::sat_wide(qq + kk);
    endfunction

    function automatic qri_pkg::wquat_t upd_quat(input qri_pkg::qquat_t q,
                                                 input qri_pkg::wquat_t k,
                                                 input logic halve);
        qri_pkg::wquat_t r;
        r.s = upd(q.s, k.s, halve);
        r.x = upd(q.x, k.x, halve);
        r.y = upd(q.y, k.y, halve);
        r.z = upd(q.z, k.z, halve);
        return r;
    endfunction

    // configuration register, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_time_reg <= qri_pkg::STEP_TIME_RESET;
        else if (cfg.valid)
            step_time_reg <= cfg.data;
    end

    // pipe advance and valid chain
    assign en           = !valid_reg[qri_pkg::PIPE_LEN-1] || result.ready;
    assign sample.ready = en;
    assign valid_next   = {valid_reg[qri_pkg::PIPE_LEN-2:0], sample.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    // half-step rate: dt*w/2^15, truncated toward zero
    assign rate_in[0] = sample.rate_x;
    assign rate_in[1] = sample.rate_y;
    assign rate_in[2] = sample.rate_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = PRW'($signed({1'b0, step_time_reg})) * PRW'(rate_in[i]);
            adj[i] = prod_reg[i] + (prod_reg[i][PRW-1] ? H_BIAS : '0);
        end
        h_next.x = HW'(adj[0] >>> 15);
        h_next.y = HW'(adj[1] >>> 15);
        h_next.z = HW'(adj[2] >>> 15);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg.s <= sample.quat_scalar;
            q0_reg.x <= sample.quat_x;
            q0_reg.y <= sample.quat_y;
            q0_reg.z <= sample.quat_z;
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            q1_reg <= q0_reg;
            h_reg  <= h_next;
            // intermediate stage points
            p2_reg <= upd_quat(q_t6, k1, 1'b1);
            p3_reg <= upd_quat(q_t12, k2, 1'b1);
            p4_reg <= upd_quat(q_t18, k3, 1'b0);
        end
    end

    assign p1.s = widen(q1_reg.s);
    assign p1.x = widen(q1_reg.x);
    assign p1.y = widen(q1_reg.y);
    assign p1.z = widen(q1_reg.z);

    // alignment lines for h and q
    qri_delay #(.WIDTH($bits(qri_pkg::hvec_t)), .DEPTH(6)) u_hd1
        (.clk(clk), .en(en), .d(h_reg), .q(h_d1));
    qri_delay #(.WIDTH($bits(qri_pkg::hvec_t)), .DEPTH(6)) u_hd2
        (.clk(clk), .en(en), .d(h_d1), .q(h_d2));
    qri_delay #(.WIDTH($bits(qri_pkg::hvec_t)), .DEPTH(6)) u_hd3
        (.clk(clk), .en(en), .d(h_d2), .q(h_d3));
    qri_delay #(.WIDTH($bits(qri_pkg::qquat_t)), .DEPTH(5)) u_qd1
        (.clk(clk), .en(en), .d(q1_reg), .q(q_t6));
    qri_delay #(.WIDTH($bits(qri_pkg::qquat_t)), .DEPTH(6)) u_qd2
        (.clk(clk), .en(en), .d(q_t6), .q(q_t12));
    qri_delay #(.WIDTH($bits(qri_pkg::qquat_t)), .DEPTH(6)) u_qd3
        (.clk(clk), .en(en), .d(q_t12), .q(q_t18));
    qri_delay #(.WIDTH($bits(qri_pkg::qquat_t)), .DEPTH(6)) u_qd4
        (.clk(clk), .en(en), .d(q_t18), .q(q_t24));

    // four derivative evaluations
    qri_deriv u_k1 (.clk(clk), .en(en), .p(p1),     .h(h_reg), .d(k1));
    qri_deriv u_k2 (.clk(clk), .en(en), .p(p2_reg), .h(h_d1),  .d(k2));
    qri_deriv u_k3 (.clk(clk), .en(en), .p(p3_reg), .h(h_d2),  .d(k3));
    qri_deriv u_k4 (.clk(clk), .en(en), .p(p4_reg), .h(h_d3),  .d(k4));

    // hold k1..k3 until k4 arrives
    qri_delay #(.WIDTH($bits(qri_pkg::wquat_t)), .DEPTH(18)) u_k1d
        (.clk(clk), .en(en), .d(k1), .q(k1_d));
    qri_delay #(.WIDTH($bits(qri_pkg::wquat_t)), .DEPTH(12)) u_k2d
        (.clk(clk), .en(en), .d(k2), .q(k2_d));
    qri_delay #(.WIDTH($bits(qri_pkg::wquat_t)), .DEPTH(6)) u_k3d
        (.clk(clk), .en(en), .d(k3), .q(k3_d));

    // weighted combination per component
    assign k1a = '{k1_d.s, k1_d.x, k1_d.y, k1_d.z};
    assign k2a = '{k2_d.s, k2_d.x, k2_d.y, k2_d.z};
    assign k3a = '{k3_d.s, k3_d.x, k3_d.y, k3_d.z};
    assign k4a = '{k4.s, k4.x, k4.y, k4.z};
    assign qa  = '{q_t24.s, q_t24.x, q_t24.y, q_t24.z};

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        qri_final u_final (
            .clk (clk),
            .en  (en),
            .k1  (k1a[g]),
            .k2  (k2a[g]),
            .k3  (k3a[g]),
            .k4  (k4a[g]),
            .q   (qa[g]),
            .r   (r_lane[g])
        );
    end

    assign result.valid       = valid_reg[qri_pkg::PIPE_LEN-1];
    assign result.next_scalar = r_lane[0];
    assign result.next_x      = r_lane[1];
    assign result.next_y      = r_lane[2];
    assign result.next_z      = r_lane[3];

    // checks
    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("valid chain moved while the pipe was frozen");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == '0) |-> sample.ready)
        else $error("empty pipe refused an input beat");

    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        en && valid_reg[qri_pkg::PIPE_LEN-2] |=> result.valid)
        else $error("item lost before the output register");

    a_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> valid_reg[0])
        else $error("accepted beat not tracked in stage 0");

endmodule

// ===== hw/rtl/qri_delay.sv =====
// qri_delay: enabled shift line that keeps payload aligned with the pipe.
// No package dependency.
`timescale 1ns / 1ps

module qri_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // shift on every pipe advance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

// ===== hw/rtl/qri_mul.sv =====
// qri_mul: four-stage Q.30 multiplier, wide value times half-step rate,
// truncating toward zero and saturating. Depends on qri_pkg.
`timescale 1ns / 1ps

module qri_mul (
    input  logic           clk,
    input  logic           en,
    input  qri_pkg::wide_t a,
    input  qri_pkg::half_t b,
    output qri_pkg::wide_t p
);

    localparam int AMW = qri_pkg::WW;       // |a| up to 2^60
    localparam int BMW = qri_pkg::HW - 1;   // |b| below 2^40
    localparam int LW  = 31;                // low limb
    localparam int A1W = AMW - LW;
    localparam int B1W = BMW - LW;
    localparam int SW  = 72;

    logic [AMW-1:0] a_mag_reg;
    logic [BMW-1:0] b_mag_reg;
    logic           neg1_reg, neg2_reg, neg3_reg;
    logic [A1W+B1W-1:0] pp11_reg;
    logic [A1W+LW-1:0]  pp10_reg;
    logic [LW+B1W-1:0]  pp01_reg;
    logic [2*LW-1:0]    pp00_reg;
    logic [AMW-1:0] clip_reg;
    qri_pkg::wide_t p_reg;

    logic [AMW-1:0] a_mag_next;
    logic [BMW-1:0] b_mag_next;
    logic [SW-1:0]  mag;
    logic [AMW-1:0] clip_next;
    qri_pkg::wide_t p_next;

    // stage 1: magnitudes and sign
    always_comb
    begin
        a_mag_next = a[qri_pkg::WW-1] ? AMW'(-a) : AMW'(a);
        b_mag_next = b[qri_pkg::HW-1] ? BMW'(-b) : BMW'(b);
    end

    // stage 3: shifted sum of partial products, clipped at 2^60
    always_comb
    begin
        mag = (SW'(pp11_reg) << 32)
            + (SW'(pp10_reg) + SW'(pp01_reg)) * SW'(2)
            + SW'(pp00_reg[2*LW-1:30]);
        if (mag >= (SW'(1) << (AMW-1)))
            clip_next = {1'b1, {(AMW-1){1'b0}}};
        else
            clip_next = mag[AMW-1:0];
    end

    // stage 4: sign back on, positive side stops one short
    always_comb
    begin
        if (neg3_reg)
            p_next = qri_pkg::wide_t'(~clip_reg + AMW'(1));
        else if (clip_reg[AMW-1])
            p_next = qri_pkg::WIDE_MAX;
        else
            p_next = qri_pkg::wide_t'(clip_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg <= a_mag_next;
            b_mag_reg <= b_mag_next;
            neg1_reg  <= a[qri_pkg::WW-1] ^ b[qri_pkg::HW-1];
            // stage 2: limb products
            pp11_reg  <= a_mag_reg[AMW-1:LW] * b_mag_reg[BMW-1:LW];
            pp10_reg  <= a_mag_reg[AMW-1:LW] * b_mag_reg[LW-1:0];
            pp01_reg  <= a_mag_reg[LW-1:0] * b_mag_reg[BMW-1:LW];
            pp00_reg  <= a_mag_reg[LW-1:0] * b_mag_reg[LW-1:0];
            neg2_reg  <= neg1_reg;
            clip_reg  <= clip_next;
            neg3_reg  <= neg2_reg;
            p_reg     <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/qri_deriv.sv =====
// qri_deriv: quaternion rate G(p)*h, twelve multipliers and a saturating
// sum stage. Depends on qri_pkg and qri_mul.
`timescale 1ns / 1ps

module qri_deriv (
    input  logic            clk,
    input  logic            en,
    input  qri_pkg::wquat_t p,
    input  qri_pkg::hvec_t  h,
    output qri_pkg::wquat_t d
);

    // operand selection per product
    localparam int P_SEL [12] = '{1, 2, 3, 0, 2, 3, 0, 3, 1, 0, 1, 2};
    localparam int H_SEL [12] = '{0, 1, 2, 0, 2, 1, 1, 0, 2, 2, 1, 0};

    qri_pkg::wide_t  pa [4];
    qri_pkg::half_t  hb [3];
    qri_pkg::wide_t  m  [12];
    logic signed [63:0] sum [4];
    qri_pkg::wquat_t d_reg;
    qri_pkg::wquat_t d_next;

    assign pa[0] = p.s;
    assign pa[1] = p.x;
    assign pa[2] = p.y;
    assign pa[3] = p.z;
    assign hb[0] = h.x;
    assign hb[1] = h.y;
    assign hb[2] = h.z;

    for (genvar g = 0; g < 12; g++)
    begin : g_mul
        qri_mul u_mul (
            .clk (clk),
            .en  (en),
            .a   (pa[P_SEL[g]]),
            .b   (hb[H_SEL[g]]),
            .p   (m[g])
        );
    end

    // scalar: -qv.h ; vector: q0*h + qv x h
    always_comb
    begin
        sum[0] = -(qri_pkg::ext64(m[0]) + qri_pkg::ext64(m[1]) + qri_pkg::ext64(m[2]));
        sum[1] = qri_pkg::ext64(m[3]) + qri_pkg::ext64(m[4]) - qri_pkg::ext64(m[5]);
        sum[2] = qri_pkg::ext64(m[6]) + qri_pkg::ext64(m[7]) - qri_pkg::ext64(m[8]);
        sum[3] = qri_pkg::ext64(m[9]) + qri_pkg::ext64(m[10]) - qri_pkg::ext64(m[11]);
        d_next.s = qri_pkg::sat_wide(sum[0]);
        d_next.x = qri_pkg::sat_wide(sum[1]);
        d_next.y = qri_pkg::sat_wide(sum[2]);
        d_next.z = qri_pkg::sat_wide(sum[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d = d_reg;

endmodule

// ===== hw/rtl/qri_final.sv =====
// qri_final: one lane of q + (k1+2k2+2k3+k4)/6 with divide by 6 via
// reciprocal and output saturation. Depends on qri_pkg.
`timescale 1ns / 1ps

module qri_final (
    input  logic           clk,
    input  logic           en,
    input  qri_pkg::wide_t k1,
    input  qri_pkg::wide_t k2,
    input  qri_pkg::wide_t k3,
    input  qri_pkg::wide_t k4,
    input  qri_pkg::q_t    q,
    output qri_pkg::q_t    r
);

    localparam int DW  = qri_pkg::DIVW;
    localparam int MW  = 2 * DW;
    localparam int QVW = MW - 35;

    logic signed [63:0] s;
    logic [62:0]        s_mag;
    logic [61:0]        s_half;
    logic               neg1_reg, neg2_reg;
    logic               big1_reg, big2_reg;
    logic [DW-1:0]      x1_reg;
    logic [MW-1:0]      prod2_reg;
    qri_pkg::q_t        q1_reg, q2_reg, r_reg;

    logic [QVW-1:0]     qv;
    logic signed [34:0] sq;
    logic signed [34:0] r_sum;
    qri_pkg::q_t        r_next;

    // stage 1: weighted sum, magnitude halved, saturation flag
    always_comb
    begin
        s = qri_pkg::ext64(k1) + (qri_pkg::ext64(k2) <<< 1)
          + (qri_pkg::ext64(k3) <<< 1) + qri_pkg::ext64(k4);
        s_mag  = s[63] ? 63'(-s) : s[62:0];
        s_half = s_mag[62:1];
    end

    // stage 3: quotient, sign, add q and clamp
    always_comb
    begin
        qv    = prod2_reg[MW-1:35];
        sq    = neg2_reg ? -$signed({2'b00, qv}) : $signed({2'b00, qv});
        r_sum = {{3{q2_reg[31]}}, q2_reg} + sq;
        if (big2_reg)
            r_next = neg2_reg ? qri_pkg::Q_MIN : qri_pkg::Q_MAX;
        else if (r_sum > 35'sh0_7FFF_FFFF)
            r_next = qri_pkg::Q_MAX;
        else if (r_sum < -35'sh0_8000_0000)
            r_next = qri_pkg::Q_MIN;
        else
            r_next = r_sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg  <= s[63];
            big1_reg  <= (s_half >= qri_pkg::DIV_LIM);
            x1_reg    <= s_half[DW-1:0];
            q1_reg    <= q;
            // stage 2: multiply by reciprocal of 3
            prod2_reg <= MW'(x1_reg) * MW'(qri_pkg::RECIP3);
            neg2_reg  <= neg1_reg;
            big2_reg  <= big1_reg;
            q2_reg    <= q1_reg;
            r_reg     <= r_next;
        end
    end

    assign r = r_reg;

endmodule
